@@ rtl/twa_pkg.sv @@
// ----------------------------------------------------------------------------
// twa_pkg: shared types and constants
// Command codes, field widths, controller states, ctrl/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none
package twa_pkg;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned AGE_W    = 8;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned CMD_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_GET    = 2'd1,
        CMD_FILTER = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_PUSH,
        ST_GET,
        ST_WALK,
        ST_DIV,
        ST_NONE,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic clear_wr;  // write zero at sweep address
        logic rd;        // issue memory read
        logic push;      // finish push
        logic get;       // finish get
        logic walk;      // accumulate one walk step
        logic div_start;
        logic div_step;
        logic none;      // unused command result
        logic out_take;  // result transaction done
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic walk_done;
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/twa_ctrl.sv @@
// ----------------------------------------------------------------------------
// twa_ctrl: command sequencer
// Steps the clearing sweep, reads, walk, divide and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module twa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_fire,
    input  wire twa_pkg::t_cmd i_cmd,
    input  wire logic          i_out_fire,
    input  wire twa_pkg::t_stat i_stat,
    output twa_pkg::t_ctrl     o_ctrl,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import twa_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd,   n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cmd   <= CMD_NONE;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clear_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_cmd   = i_cmd;
                    n_state = (i_cmd == CMD_NONE) ? ST_NONE : ST_RD;
                end
            end
            ST_RD: begin
                unique case (r_cmd)
                    CMD_PUSH:   n_state = ST_PUSH;
                    CMD_GET:    n_state = ST_GET;
                    CMD_FILTER: n_state = ST_WALK;
                    default:    n_state = ST_NONE;
                endcase
            end
            ST_PUSH, ST_GET, ST_NONE: n_state = ST_OUT;
            ST_WALK: if (i_stat.walk_done) n_state = ST_DIV;
            ST_DIV:  if (i_stat.div_done)  n_state = ST_OUT;
            ST_OUT:  if (i_out_fire)       n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl           = '0;
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_ctrl.clear_wr = 1'b1;
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_fire;
            end
            ST_RD:   o_ctrl.rd   = 1'b1;
            ST_PUSH: o_ctrl.push = 1'b1;
            ST_GET:  o_ctrl.get  = 1'b1;
            ST_NONE: o_ctrl.none = 1'b1;
            ST_WALK: begin
                o_ctrl.walk      = 1'b1;
                o_ctrl.div_start = i_stat.walk_done;
            end
            ST_DIV:  o_ctrl.div_step = 1'b1;
            ST_OUT: begin
                o_out_valid     = 1'b1;
                o_ctrl.out_take = i_out_fire;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/twa_dp.sv @@
// ----------------------------------------------------------------------------
// twa_dp: ring storage, window walk and restoring divider
// One memory read per cycle; the divider retires one quotient bit per cycle
// for all three components at once.
// ----------------------------------------------------------------------------
`default_nettype none
module twa_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire twa_pkg::t_ctrl                     i_ctrl,
    input  wire twa_pkg::t_cmd                      i_cmd,
    input  wire logic signed [twa_pkg::SAMPLE_W-1:0] i_sample_x,
    input  wire logic signed [twa_pkg::SAMPLE_W-1:0] i_sample_y,
    input  wire logic signed [twa_pkg::SAMPLE_W-1:0] i_sample_z,
    input  wire logic [twa_pkg::TIME_W-1:0]          i_sample_time,
    input  wire logic [twa_pkg::AGE_W-1:0]           i_age_index,
    input  wire logic [twa_pkg::TIME_W-1:0]          i_window_start,
    input  wire logic [twa_pkg::TIME_W-1:0]          i_window_stop,
    output twa_pkg::t_stat                           o_stat,
    output logic                                     o_found,
    output logic signed [twa_pkg::SAMPLE_W-1:0]      o_result_x,
    output logic signed [twa_pkg::SAMPLE_W-1:0]      o_result_y,
    output logic signed [twa_pkg::SAMPLE_W-1:0]      o_result_z,
    output logic [twa_pkg::TIME_W-1:0]               o_result_time,
    output logic [twa_pkg::COUNT_W-1:0]              o_sample_count
);
    import twa_pkg::*;

    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = SAMPLE_W + CW;
    localparam int unsigned ENT_W = 3 * SAMPLE_W + TIME_W;
    localparam int unsigned QW    = SUM_W;
    localparam int unsigned QCW   = $clog2(QW + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rd;

    logic [AW-1:0]  r_newest, n_newest;
    logic [AW-1:0]  r_clr;
    logic           r_clr_done;
    logic           r_mem_we;
    logic [AW-1:0]  r_wa;
    logic [ENT_W-1:0] r_wd;
    logic [AW-1:0]  r_ra;
    logic           r_rvalid;   // walk: read data in r_rd belongs to r_age-1

    // captured transaction
    logic signed [SAMPLE_W-1:0] r_sx, r_sy, r_sz;
    logic [TIME_W-1:0] r_st, r_ws, r_we;
    logic [AGE_W-1:0]  r_age_in;

    // walk state
    logic [CW-1:0]  r_age;      // next age to read
    logic [CW-1:0]  r_seen;     // entries examined
    logic           r_stop;
    logic signed [SUM_W-1:0] r_acc [3];
    logic [CW-1:0]  r_cnt;

    // divider
    logic [QW-1:0]  r_num [3];
    logic [QW-1:0]  r_rem [3];
    logic           r_neg [3];
    logic [QCW-1:0] r_bit;

    // result register
    logic r_found;
    logic signed [SAMPLE_W-1:0] r_rx, r_ry, r_rz;
    logic [TIME_W-1:0] r_rt;
    logic [COUNT_W-1:0] r_rc;

    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_age_pos;
    logic [TIME_W-1:0] w_t;
    logic [AW:0] w_sum;

    assign w_t = r_rd[TIME_W-1:0];

    // newest + age, wrapped (age < DEPTH)
    always_comb begin
        w_sum = {1'b0, r_newest} + {1'b0, r_age[AW-1:0]};
        if (r_age >= CW'(DEPTH)) w_sum = '0;
        if (w_sum >= (AW+1)'(DEPTH)) w_age_pos = AW'(w_sum - (AW+1)'(DEPTH));
        else                          w_age_pos = w_sum[AW-1:0];
    end

    always_comb begin
        logic [AW:0] s;
        s = {1'b0, r_newest} + (AW+1)'(r_age_in);
        w_rd_addr = r_newest;
        if (i_ctrl.rd && i_cmd == CMD_GET) begin
            if (s >= (AW+1)'(DEPTH)) w_rd_addr = AW'(s - (AW+1)'(DEPTH));
            else                      w_rd_addr = s[AW-1:0];
        end else if (i_ctrl.walk) begin
            w_rd_addr = w_age_pos;
        end
    end

    assign n_newest = (r_newest == '0) ? LAST : r_newest - AW'(1);

    // memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (r_mem_we) r_mem[r_wa] <= r_wd;
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest   <= '0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_mem_we   <= 1'b0;
        end else begin
            r_mem_we <= 1'b0;
            if (i_ctrl.clear_wr && !r_clr_done) begin
                r_mem_we <= 1'b1;
                r_wa     <= r_clr;
                r_wd     <= '0;
                if (r_clr == LAST) r_clr_done <= 1'b1;
                else               r_clr      <= r_clr + AW'(1);
            end
            if (i_ctrl.push) begin
                r_newest <= n_newest;
                r_mem_we <= 1'b1;
                r_wa     <= n_newest;
                r_wd     <= {r_sx, r_sy, r_sz, r_st};
            end
        end
    end

    // last clear write lands in the cycle after r_clr_done rises
    assign o_stat.clear_done = r_clr_done && !r_mem_we;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sx <= i_sample_x;  r_sy <= i_sample_y;  r_sz <= i_sample_z;
            r_st <= i_sample_time;
            r_ws <= i_window_start; r_we <= i_window_stop;
            r_age_in <= i_age_index;
        end
    end

    // walk: read ages one per cycle, consume registered data next cycle
    logic w_walk_end;
    assign w_walk_end = r_stop || (r_seen == CW'(DEPTH));
    assign o_stat.walk_done = i_ctrl.walk && w_walk_end;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_age    <= '0;
            r_seen   <= '0;
            r_rvalid <= 1'b0;
            r_stop   <= (r_ws > r_we);
            r_cnt    <= '0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
        end else if (i_ctrl.walk && !w_walk_end) begin
            if (r_age < CW'(DEPTH)) r_age <= r_age + CW'(1);
            r_rvalid <= 1'b1;
            if (r_rvalid) begin
                r_seen <= r_seen + CW'(1);
                if (w_t > r_we) begin
                end else if (w_t < r_ws) begin
                    r_stop <= 1'b1;
                end else begin
                    r_acc[0] <= r_acc[0] + SUM_W'(signed'(r_rd[ENT_W-1 -: SAMPLE_W]));
                    r_acc[1] <= r_acc[1]
                        + SUM_W'(signed'(r_rd[ENT_W-SAMPLE_W-1 -: SAMPLE_W]));
                    r_acc[2] <= r_acc[2]
                        + SUM_W'(signed'(r_rd[ENT_W-2*SAMPLE_W-1 -: SAMPLE_W]));
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // restoring divide of |sum| by count, MSB first
    assign o_stat.div_done = i_ctrl.div_step && (r_bit == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_start) begin
            r_bit <= QCW'(QW);
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_acc[i][SUM_W-1];
                r_num[i] <= r_acc[i][SUM_W-1] ? QW'(-r_acc[i]) : QW'(r_acc[i]);
                r_rem[i] <= '0;
            end
        end else if (i_ctrl.div_step && r_bit != '0) begin
            r_bit <= r_bit - QCW'(1);
            for (int i = 0; i < 3; i++) begin
                logic [QW:0] t;
                t = {r_rem[i], r_num[i][QW-1]};
                if (t >= (QW+1)'(r_cnt)) begin
                    r_rem[i] <= QW'(t - (QW+1)'(r_cnt));
                    r_num[i] <= {r_num[i][QW-2:0], 1'b1};
                end else begin
                    r_rem[i] <= t[QW-1:0];
                    r_num[i] <= {r_num[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] f_q(
        input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] v;
        v = neg ? -q : q;
        return v[SAMPLE_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_found <= (r_rd[TIME_W-1:0] <= r_st);
            r_rx <= '0; r_ry <= '0; r_rz <= '0; r_rt <= '0; r_rc <= '0;
        end else if (i_ctrl.get) begin
            r_rc <= '0;
            if (32'(r_age_in) < 32'(DEPTH)) begin
                r_found <= 1'b1;
                r_rx <= r_rd[ENT_W-1 -: SAMPLE_W];
                r_ry <= r_rd[ENT_W-SAMPLE_W-1 -: SAMPLE_W];
                r_rz <= r_rd[ENT_W-2*SAMPLE_W-1 -: SAMPLE_W];
                r_rt <= r_rd[TIME_W-1:0];
            end else begin
                r_found <= 1'b0;
                r_rx <= '0; r_ry <= '0; r_rz <= '0; r_rt <= '0;
            end
        end else if (i_ctrl.none) begin
            r_found <= 1'b0;
            r_rx <= '0; r_ry <= '0; r_rz <= '0; r_rt <= '0; r_rc <= '0;
        end else if (o_stat.div_done) begin
            r_found <= 1'b1;
            r_rt    <= '0;
            r_rc    <= COUNT_W'(r_cnt);
            if (r_cnt == '0) begin
                r_rx <= '0; r_ry <= '0; r_rz <= '0;
            end else begin
                r_rx <= f_q(r_num[0], r_neg[0]);
                r_ry <= f_q(r_num[1], r_neg[1]);
                r_rz <= f_q(r_num[2], r_neg[2]);
            end
        end
    end

    assign o_found        = r_found;
    assign o_result_x     = r_rx;
    assign o_result_y     = r_ry;
    assign o_result_z     = r_rz;
    assign o_result_time  = r_rt;
    assign o_sample_count = r_rc;
    // out_take needs no datapath action; result registers hold until reload
    logic w_unused;
    assign w_unused = i_ctrl.out_take;
endmodule
`default_nettype wire

@@ rtl/timestamped_vec3_window_average_core.sv @@
// ----------------------------------------------------------------------------
// timestamped_vec3_window_average_core: timestamped x/y/z ring with window mean
// Push/get/filter over a DEPTH-entry ring of Q16.16 samples and ns stamps.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser
//  s_axis  | in  | x, y, z, time, age, start, stop (296 bits)        | command
//  m_axis  | out | x, y, z, time, count (167 bits, padded to 168)    | found
//
// Push and get pass from accept to result valid through capture, memory read,
// update and present. Filter walks the ring one entry per cycle through the
// single read port, then runs the bit-serial divider on all three components
// at once. Reset: a clearing pass writes zero to all DEPTH entries, with
// s_axis_tready low. One transaction in flight; a stalled result holds.
// ----------------------------------------------------------------------------
`default_nettype none
module timestamped_vec3_window_average_core #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // sample_x, sample_y, sample_z, sample_time, age_index, window_start, window_stop
    input  wire logic [295:0] s_axis_tdata,
    // command
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_x, result_y, result_z, result_time, sample_count, zero pad
    output logic [167:0]      m_axis_tdata,
    // found
    output logic              m_axis_tuser
);
    import twa_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_in_fire, w_out_fire;
    logic signed [SAMPLE_W-1:0] w_rx, w_ry, w_rz;
    logic [TIME_W-1:0]  w_rt;
    logic [COUNT_W-1:0] w_rc;
    t_cmd w_cmd;

    assign w_cmd      = t_cmd'(s_axis_tuser);
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    twa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_cmd       (w_cmd),
        .i_out_fire  (w_out_fire),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    // captured command copy; datapath uses it only while rd is high
    t_cmd r_cmd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)        r_cmd <= CMD_NONE;
        else if (w_in_fire)  r_cmd <= w_cmd;
    end

    twa_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_cmd          (r_cmd),
        .i_sample_x     (s_axis_tdata[31:0]),
        .i_sample_y     (s_axis_tdata[63:32]),
        .i_sample_z     (s_axis_tdata[95:64]),
        .i_sample_time  (s_axis_tdata[159:96]),
        .i_age_index    (s_axis_tdata[167:160]),
        .i_window_start (s_axis_tdata[231:168]),
        .i_window_stop  (s_axis_tdata[295:232]),
        .o_stat         (w_stat),
        .o_found        (m_axis_tuser),
        .o_result_x     (w_rx),
        .o_result_y     (w_ry),
        .o_result_z     (w_rz),
        .o_result_time  (w_rt),
        .o_sample_count (w_rc)
    );

    assign m_axis_tdata = {1'b0, w_rc, w_rt, w_rz, w_ry, w_rx};
endmodule
`default_nettype wire

@@ test/tb_timestamped_vec3_window_average_core.sv @@
// ----------------------------------------------------------------------------
// tb_timestamped_vec3_window_average_core: stream-level check of the ring core
// Drives push/get/filter/unused transactions with bursty input and a stalling
// output, predicts every result in a scoreboard and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class ring_scoreboard;
    localparam int DEPTH = 64;
    logic [31:0]  ring_x [DEPTH];
    logic [31:0]  ring_y [DEPTH];
    logic [31:0]  ring_z [DEPTH];
    logic [63:0]  ring_t [DEPTH];
    int           newest;
    logic [168:0] pending [$];   // {found, tdata}
    int           errors;
    int           checked;

    function new();
        newest = 0;
        errors = 0;
        checked = 0;
        for (int i = 0; i < DEPTH; i++) begin
            ring_x[i] = '0;
            ring_y[i] = '0;
            ring_z[i] = '0;
            ring_t[i] = '0;
        end
    endfunction

    // note an accepted input transaction and queue its predicted result
    function void note_input(twa_pkg::t_cmd cmd, logic [295:0] d);
        logic [31:0]  sx, sy, sz, rx, ry, rz;
        logic [63:0]  st, wstart, wstop, rt, ts;
        logic [7:0]   age;
        logic         fnd;
        logic [6:0]   cnt;
        longint       ax, ay, az, n;
        int           pos;
        sx = d[31:0];
        sy = d[63:32];
        sz = d[95:64];
        st = d[159:96];
        age = d[167:160];
        wstart = d[231:168];
        wstop = d[295:232];
        fnd = 0; rx = 0; ry = 0; rz = 0; rt = 0; cnt = 0;
        ax = 0; ay = 0; az = 0; n = 0;
        case (cmd)
            twa_pkg::CMD_PUSH: begin
                fnd = ring_t[newest] <= st;
                newest = (newest == 0) ? DEPTH - 1 : newest - 1;
                ring_x[newest] = sx;
                ring_y[newest] = sy;
                ring_z[newest] = sz;
                ring_t[newest] = st;
            end
            twa_pkg::CMD_GET: begin
                if (age < DEPTH) begin
                    pos = (newest + age) % DEPTH;
                    fnd = 1;
                    rx = ring_x[pos]; ry = ring_y[pos]; rz = ring_z[pos];
                    rt = ring_t[pos];
                end
            end
            twa_pkg::CMD_FILTER: begin
                fnd = 1;
                if (wstart <= wstop) begin
                    for (int a = 0; a < DEPTH; a++) begin
                        pos = (newest + a) % DEPTH;
                        ts = ring_t[pos];
                        if (ts > wstop) continue;
                        if (ts < wstart) break;
                        ax += longint'(signed'(ring_x[pos]));
                        ay += longint'(signed'(ring_y[pos]));
                        az += longint'(signed'(ring_z[pos]));
                        n++;
                    end
                end
                if (n > 0) begin
                    // SV signed division truncates toward zero
                    rx = 32'(ax / n); ry = 32'(ay / n); rz = 32'(az / n);
                end
                cnt = 7'(n);
            end
            default: ;
        endcase
        pending.push_back({fnd, 1'b0, cnt, rt, rz, ry, rx});
    endfunction

    function void check_result(logic fnd, logic [167:0] d);
        logic [168:0] e;
        checked++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result found=%0b data=%h", $time, fnd, d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e[168] !== fnd) begin
            $display("%0t: found exp %0b act %0b", $time, e[168], fnd);
            errors++;
        end
        if (e[31:0] !== d[31:0]) begin
            $display("%0t: x exp %h act %h", $time, e[31:0], d[31:0]);
            errors++;
        end
        if (e[63:32] !== d[63:32]) begin
            $display("%0t: y exp %h act %h", $time, e[63:32], d[63:32]);
            errors++;
        end
        if (e[95:64] !== d[95:64]) begin
            $display("%0t: z exp %h act %h", $time, e[95:64], d[95:64]);
            errors++;
        end
        if (e[159:96] !== d[159:96]) begin
            $display("%0t: time exp %h act %h", $time, e[159:96], d[159:96]);
            errors++;
        end
        if (e[167:160] !== d[167:160]) begin
            $display("%0t: count/pad exp %h act %h", $time, e[167:160], d[167:160]);
            errors++;
        end
    endfunction
endclass

module tb_timestamped_vec3_window_average_core;
    import twa_pkg::*;

    localparam int DEPTH     = 64;
    localparam int N_RANDOM  = 650;
    localparam int MAX_CYCLE = 1500000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata = '0;   // x, y, z, time, age, start, stop
    logic [1:0]   s_axis_tuser = '0;   // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [167:0] m_axis_tdata;        // x, y, z, time, count, pad
    logic         m_axis_tuser;        // found

    ring_scoreboard board = new();
    int     cycles = 0;
    int     n_sent = 0;
    int     hold_off = 0;      // long receiver stall, cycles remaining
    bit     stall_mode = 0;    // 0: no stalls, 1: random stalls
    logic [63:0] clock_ns = 0; // rising timestamp for well-formed pushes
    logic [63:0] last_ts [$];  // recent pushed stamps for window picking

    timestamped_vec3_window_average_core #(.DEPTH(DEPTH)) dut (.*);

    always #10 i_clk = ~i_clk;

    // receiver: takes results, stalls on its own pattern, plus long hold-offs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("timestamped_vec3_window_average_core test failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else if (stall_mode)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= 1;
    end

    // present one transaction and hold it until accepted
    task automatic send_item(t_cmd cmd, logic [295:0] d);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(cmd, d);
        n_sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [295:0] pack_in(logic [31:0] x, logic [31:0] y,
            logic [31:0] z, logic [63:0] t, logic [7:0] age,
            logic [63:0] ws, logic [63:0] we);
        return {we, ws, age, t, z, y, x};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_ordered();
        logic [63:0] t;
        clock_ns = clock_ns + $urandom_range(0, 1000);
        t = clock_ns;
        last_ts.push_back(t);
        if (last_ts.size() > 80) void'(last_ts.pop_front());
        send_item(CMD_PUSH, pack_in(rand_sample(), rand_sample(), rand_sample(),
                  t, $urandom(), rand64(), rand64()));
    endtask

    task automatic random_item();
        int          sel;
        logic [63:0] a, b;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            push_ordered();
        else if (sel < 45)       // noise push: any stamp, often out of order
            send_item(CMD_PUSH, pack_in(rand_sample(), rand_sample(), rand_sample(),
                      rand64(), $urandom(), rand64(), rand64()));
        else if (sel < 62)
            send_item(CMD_GET, pack_in($urandom(), $urandom(), $urandom(), rand64(),
                      $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 63),
                      rand64(), rand64()));
        else if (sel < 96) begin
            // windows mostly drawn from recent stamps so they hit real entries
            if (last_ts.size() > 0 && sel < 90) begin
                a = last_ts[$urandom_range(0, last_ts.size() - 1)];
                b = last_ts[$urandom_range(0, last_ts.size() - 1)];
                if (a > b && sel < 86) {a, b} = {b, a};
            end else begin
                a = rand64();
                b = rand64();
            end
            send_item(CMD_FILTER, pack_in($urandom(), $urandom(), $urandom(),
                      rand64(), $urandom(), a, b));
        end else
            send_item(CMD_NONE, pack_in($urandom(), $urandom(), $urandom(),
                      rand64(), $urandom(), rand64(), rand64()));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: empty ring, extremes, every command and special case
        stall_mode = 0;
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, '0, '0));
        send_item(CMD_GET, pack_in('0, '0, '0, '0, 8'd0, '0, '0));
        send_item(CMD_PUSH, pack_in(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  64'd5, 8'hFF, '1, '1));
        send_item(CMD_PUSH, pack_in(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                  64'd10, '0, '0, '0));
        send_item(CMD_PUSH, pack_in(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
                  64'd3, '0, '0, '0));                      // out of order
        send_item(CMD_GET, pack_in('1, '1, '1, '1, 8'd63, '1, '1));
        send_item(CMD_GET, pack_in('0, '0, '0, '0, 8'd64, '0, '0));  // too old
        send_item(CMD_GET, pack_in('0, '0, '0, '0, 8'hFF, '0, '0));
        send_item(CMD_GET, pack_in('0, '0, '0, '0, 8'd1, '0, '0));
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, 64'd0, '1));
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, 64'd4, 64'd10));
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, 64'd11, 64'd10)); // inverted
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, 64'd6, 64'd9));   // empty
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, '1, '1));
        send_item(CMD_NONE, pack_in('1, '1, '1, '1, '1, '1, '1));
        send_item(CMD_PUSH, pack_in('0, '0, '0, '1, '0, '0, '0));
        send_item(CMD_PUSH, pack_in('1, '1, '1, '0, '1, '1, '1));
        // fill the whole ring so every entry is in play
        for (int i = 0; i < DEPTH + 2; i++) push_ordered();
        send_item(CMD_FILTER, pack_in('0, '0, '0, '0, '0, '0, '1));
        wait_drained();   // sender pauses until every result is back

        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        for (int i = 0; i < 20; i++) random_item();

        // random part: bursts with gaps, receiver stalls in some phases
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 150 == 0) stall_mode = ~stall_mode;
            random_item();
            if ($urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 12));
        end

        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d transactions (push, get, filter, unused).", n_sent);
        $display("Checked %0d results against the scoreboard.", board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("timestamped_vec3_window_average_core test passed");
        else
            $display("timestamped_vec3_window_average_core test failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ sim.f @@
rtl/twa_pkg.sv
rtl/twa_ctrl.sv
rtl/twa_dp.sv
rtl/timestamped_vec3_window_average_core.sv
test/tb_timestamped_vec3_window_average_core.sv
